FILE: hw/rtl/multi_operand_gcd_assert.svh
// Assertion macros shared by the multi-operand GCD RTL.
`ifndef MULTI_OPERAND_GCD_ASSERT_SVH
`define MULTI_OPERAND_GCD_ASSERT_SVH

// Property checked at every clock edge outside reset.
`define MOG_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Consequent must hold on the edge after the antecedent.
`define MOG_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/mog_pkg.sv
// Types and constants for the multi-operand GCD block.
`default_nettype none

package mog_pkg;

	localparam int unsigned MOG_DATA_WIDTH = 64;
	localparam int unsigned FIELD_WIDTH    = 64;
	localparam int unsigned FMT_WIDTH      = 3;
	localparam logic [FMT_WIDTH-1:0] RESULT_FORMAT_RESET = 3'd7;

	// operand/result size selected by format bits [2:1]
	typedef enum logic [1:0] {
		SZ_8  = 2'd0,
		SZ_16 = 2'd1,
		SZ_32 = 2'd2,
		SZ_64 = 2'd3
	} size_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FOLD,
		ST_EMIT
	} top_state_t;

	typedef enum logic {
		GCD_IDLE,
		GCD_RUN
	} gcd_state_t;

	function automatic logic [FIELD_WIDTH-1:0] fmt_mask(input logic [FMT_WIDTH-1:0] fmt);
		logic [FIELD_WIDTH-1:0] m;
		m = '0;
		unique case (size_t'(fmt[2:1]))
			SZ_8:    m[7:0]  = '1;
			SZ_16:   m[15:0] = '1;
			SZ_32:   m[31:0] = '1;
			SZ_64:   m       = '1;
			default: m       = '1;
		endcase
		return m;
	endfunction

	function automatic logic fmt_top_bit(input logic [FIELD_WIDTH-1:0] x,
			input logic [FMT_WIDTH-1:0] fmt);
		logic b;
		unique case (size_t'(fmt[2:1]))
			SZ_8:    b = x[7];
			SZ_16:   b = x[15];
			SZ_32:   b = x[31];
			SZ_64:   b = x[63];
			default: b = x[63];
		endcase
		return b;
	endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/mog_gcd_core.sv
// Iterative binary GCD unit: one shift, swap or subtract per cycle.
`default_nettype none

module mog_gcd_core import mog_pkg::*; #(
	parameter int unsigned DATA_WIDTH = MOG_DATA_WIDTH
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic [DATA_WIDTH-1:0] a_init,
	input  wire logic [DATA_WIDTH-1:0] b_init,
	output logic                       done,
	output logic [DATA_WIDTH-1:0]      result
);

	localparam int unsigned SHW = $clog2(DATA_WIDTH);

	gcd_state_t            state_q, state_d;
	logic [DATA_WIDTH-1:0] a_q, a_d, b_q, b_d, result_q, result_d;
	logic [SHW-1:0]        k_q, k_d;
	logic                  done_q, done_d;
	logic [DATA_WIDTH:0]   diff;
	logic                  borrow;

	assign diff   = {1'b0, a_q} - {1'b0, b_q};
	assign borrow = diff[DATA_WIDTH];

	always_comb begin
		state_d  = state_q;
		a_d      = a_q;
		b_d      = b_q;
		k_d      = k_q;
		done_d   = 1'b0;
		result_d = result_q;
		unique case (state_q)
			GCD_IDLE: begin
				if (start) begin
					a_d     = a_init;
					b_d     = b_init;
					k_d     = '0;
					state_d = GCD_RUN;
				end
			end
			GCD_RUN: begin
				if (a_q == '0 || b_q == '0) begin
					// one side is zero: the other, scaled back by the common twos
					result_d = (a_q | b_q) << k_q;
					done_d   = 1'b1;
					state_d  = GCD_IDLE;
				end else if (!a_q[0] && !b_q[0]) begin
					a_d = a_q >> 1;
					b_d = b_q >> 1;
					k_d = k_q + 1'b1;
				end else if (!a_q[0]) begin
					a_d = a_q >> 1;
				end else if (!b_q[0]) begin
					b_d = b_q >> 1;
				end else if (borrow) begin
					// keep the larger value in a
					a_d = b_q;
					b_d = a_q;
				end else begin
					a_d = diff[DATA_WIDTH-1:0];
				end
			end
			default: state_d = GCD_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= GCD_IDLE;
			done_q  <= 1'b0;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
			k_q     <= k_d;
		end
	end

	always_ff @(posedge clk) begin
		a_q      <= a_d;
		b_q      <= b_d;
		result_q <= result_d;
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

`default_nettype wire

FILE: hw/rtl/multi_operand_gcd.sv
// Multi-operand GCD: folds each operand magnitude into a running GCD.
// Timing: an operand is folded by the binary GCD loop in the subtract/shift unit;
// a last operand then passes through the emit state, which loads the result
// register once no earlier beat is held there by a stall.
// Throughput: one operand at a time; the next is taken once the fold (and emit) ends.
// Reset (arst_n low): running GCD cleared, result_format set to u64, no beat pending.
`default_nettype none
`include "multi_operand_gcd_assert.svh"

module multi_operand_gcd import mog_pkg::*; #(
	parameter int unsigned DATA_WIDTH = MOG_DATA_WIDTH
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_stall,
	input  wire logic [FIELD_WIDTH-1:0] operand_bits,
	input  wire logic [FMT_WIDTH-1:0]   operand_format,
	input  wire logic                   last_operand,
	output logic                        out_valid,
	input  wire logic                   out_stall,
	output logic [FIELD_WIDTH-1:0]      gcd_value,
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [FMT_WIDTH-1:0]   result_format
);

	top_state_t             state_q, state_d;
	logic                   last_q;
	logic [DATA_WIDTH-1:0]  acc_q;
	logic                   out_valid_q;
	logic [FIELD_WIDTH-1:0] gcd_q;
	logic [FMT_WIDTH-1:0]   result_format_q;

	logic                   accept, slot_free, emit;
	logic [FIELD_WIDTH-1:0] op_mask, op_x, op_mag, acc_ext;
	logic [DATA_WIDTH-1:0]  core_result;
	logic                   core_done;

	assign accept    = in_valid && !in_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign slot_free = !out_valid_q || !out_stall;
	assign emit      = (state_q == ST_EMIT) && slot_free;
	// hold off format writes while an operand is being folded or emitted
	assign cfg_ready = (state_q == ST_IDLE);

	// magnitude of the operand at its own width, signed codes are even
	always_comb begin
		op_mask = fmt_mask(operand_format);
		op_x    = operand_bits & op_mask;
		if (!operand_format[0] && fmt_top_bit(op_x, operand_format))
			op_mag = (~op_x + 64'd1) & op_mask;
		else
			op_mag = op_x;
	end

	always_comb begin
		acc_ext                 = '0;
		acc_ext[DATA_WIDTH-1:0] = acc_q;
	end

	mog_gcd_core #(
		.DATA_WIDTH (DATA_WIDTH)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept),
		.a_init (acc_q),
		.b_init (op_mag[DATA_WIDTH-1:0]),
		.done   (core_done),
		.result (core_result)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (accept) state_d = ST_FOLD;
			ST_FOLD: begin
				if (core_done)
					state_d = last_q ? ST_EMIT : ST_IDLE;
			end
			ST_EMIT: if (slot_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			acc_q           <= '0;
			out_valid_q     <= 1'b0;
			result_format_q <= RESULT_FORMAT_RESET;
		end else begin
			state_q <= state_d;
			if (core_done)
				acc_q <= core_result;
			else if (emit)
				acc_q <= '0;
			// hold the beat while stalled
			if (emit)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			if (cfg_valid && cfg_ready)
				result_format_q <= result_format;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			last_q <= last_operand;
		if (emit)
			gcd_q <= acc_ext & fmt_mask(result_format_q);
	end

	assign out_valid = out_valid_q;
	assign gcd_value = gcd_q;

	`MOG_ASSERT(a_done_in_fold, core_done |-> state_q == ST_FOLD, "GCD unit finished outside a fold")
	`MOG_ASSERT(a_emit_last, state_q == ST_EMIT |-> last_q, "result emitted for an operand not marked last")
	`MOG_ASSERT_NEXT(a_acc_clear, emit, acc_q == '0 && out_valid_q, "running GCD not cleared on emit")

endmodule

`default_nettype wire

FILE: bench/gcd_checker.sv
// Checker for the multi-operand GCD block: folds accepted operands and compares each result beat.
module gcd_checker import mog_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic                   in_stall,
	input  logic [FIELD_WIDTH-1:0] operand_bits,
	input  logic [FMT_WIDTH-1:0]   operand_format,
	input  logic                   last_operand,
	input  logic                   out_valid,
	input  logic                   out_stall,
	input  logic [FIELD_WIDTH-1:0] gcd_value,
	input  logic                   cfg_valid,
	input  logic                   cfg_ready,
	input  logic [FMT_WIDTH-1:0]   result_format,
	output int                     fail_count,
	output int                     pending_count
);

	logic [FIELD_WIDTH-1:0] running_gcd;
	logic [FMT_WIDTH-1:0]   result_fmt;
	logic [FIELD_WIDTH-1:0] gcd_expect_q[$];

	function automatic int unsigned fmt_width(input logic [FMT_WIDTH-1:0] fmt);
		case (size_t'(fmt[2:1]))
			SZ_8:    return 8;
			SZ_16:   return 16;
			SZ_32:   return 32;
			default: return 64;
		endcase
	endfunction

	function automatic logic [FIELD_WIDTH-1:0] fmt_ones(input logic [FMT_WIDTH-1:0] fmt);
		logic [FIELD_WIDTH-1:0] m;
		m = '1;
		if (fmt_width(fmt) < 64)
			m = (64'd1 << fmt_width(fmt)) - 64'd1;
		return m;
	endfunction

	// Even codes are two's complement: take the magnitude, the most negative value included.
	function automatic logic [FIELD_WIDTH-1:0] magnitude(input logic [FIELD_WIDTH-1:0] bits,
			input logic [FMT_WIDTH-1:0] fmt);
		logic [FIELD_WIDTH-1:0] m;
		logic [FIELD_WIDTH-1:0] x;
		m = fmt_ones(fmt);
		x = bits & m;
		if (!fmt[0] && x[fmt_width(fmt)-1])
			x = (~x + 64'd1) & m;
		return x;
	endfunction

	function automatic logic [FIELD_WIDTH-1:0] gcd_of(input logic [FIELD_WIDTH-1:0] a,
			input logic [FIELD_WIDTH-1:0] b);
		logic [FIELD_WIDTH-1:0] t;
		while (b != 0) begin
			t = a % b;
			a = b;
			b = t;
		end
		return a;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		logic [FIELD_WIDTH-1:0] mag;
		logic [FIELD_WIDTH-1:0] want;
		if (!arst_n) begin
			running_gcd = '0;
			result_fmt = RESULT_FORMAT_RESET;
			gcd_expect_q.delete();
			fail_count <= 0;
			pending_count <= 0;
		end else begin
			if (cfg_valid && cfg_ready)
				result_fmt = result_format;
			if (out_valid && !out_stall) begin
				if (gcd_expect_q.size() == 0) begin
					$error("gcd_value: no beat expected, got %h", gcd_value);
					fail_count <= fail_count + 1;
				end else begin
					want = gcd_expect_q.pop_front();
					if (gcd_value !== want) begin
						$error("gcd_value: expected %h, got %h", want, gcd_value);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (in_valid && !in_stall) begin
				mag = magnitude(operand_bits, operand_format);
				if (mag != 0)
					running_gcd = gcd_of(running_gcd, mag);
				if (last_operand) begin
					gcd_expect_q.push_back(running_gcd & fmt_ones(result_fmt));
					running_gcd = '0;
				end
			end
			pending_count <= gcd_expect_q.size();
		end
	end

endmodule

FILE: bench/tb_multi_operand_gcd.sv
// Testbench top for the multi-operand GCD block: stimulus, receiver stalls and verdict.
module tb_multi_operand_gcd;
	import mog_pkg::*;

	localparam logic [FMT_WIDTH-1:0] FMT_I8  = 3'd0;
	localparam logic [FMT_WIDTH-1:0] FMT_U8  = 3'd1;
	localparam logic [FMT_WIDTH-1:0] FMT_I16 = 3'd2;
	localparam logic [FMT_WIDTH-1:0] FMT_U16 = 3'd3;
	localparam logic [FMT_WIDTH-1:0] FMT_I32 = 3'd4;
	localparam logic [FMT_WIDTH-1:0] FMT_U32 = 3'd5;
	localparam logic [FMT_WIDTH-1:0] FMT_I64 = 3'd6;
	localparam logic [FMT_WIDTH-1:0] FMT_U64 = 3'd7;
	localparam int PHASE_ITEMS = 112;
	localparam int SETTLE_CYCLES = 250;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   in_valid;
	logic                   in_stall;
	logic [FIELD_WIDTH-1:0] operand_bits;
	logic [FMT_WIDTH-1:0]   operand_format;
	logic                   last_operand;
	logic                   out_valid;
	logic                   out_stall;
	logic [FIELD_WIDTH-1:0] gcd_value;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [FMT_WIDTH-1:0]   result_format;
	int                     fail_count;
	int                     pending_count;

	int burst_left;
	int items_sent;
	logic set_closed;

	always #1 clk = ~clk;

	multi_operand_gcd u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.operand_bits   (operand_bits),
		.operand_format (operand_format),
		.last_operand   (last_operand),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.gcd_value      (gcd_value),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.result_format  (result_format)
	);

	gcd_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.operand_bits   (operand_bits),
		.operand_format (operand_format),
		.last_operand   (last_operand),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.gcd_value      (gcd_value),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.result_format  (result_format),
		.fail_count     (fail_count),
		.pending_count  (pending_count)
	);

	// Offer one operand; bursts of random length with random gaps between them.
	task automatic send_operand(input logic [FIELD_WIDTH-1:0] bits,
			input logic [FMT_WIDTH-1:0] fmt, input logic last);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 260) : $urandom_range(0, 6);
			burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
				: $urandom_range(1, 8);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		in_valid <= 1'b1;
		operand_bits <= bits;
		operand_format <= fmt;
		last_operand <= last;
		do @(posedge clk); while (in_stall);
		burst_left--;
		items_sent++;
		set_closed = last;
	endtask

	// Drop valid, wait for every result beat, then let any fold in flight finish.
	task automatic drain_block();
		in_valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (pending_count != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_result_format(input logic [FMT_WIDTH-1:0] fmt);
		cfg_valid <= 1'b1;
		result_format <= fmt;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// Receiver: random stall segments, and once a long hold-off so the block backs up.
	initial begin : receiver
		int mode;
		int len;
		bit long_hold_done;
		long_hold_done = 1'b0;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			if (!long_hold_done && items_sent >= 300) begin
				@(posedge clk);
				out_stall <= 1'b1;
				repeat (3000) @(posedge clk);
				long_hold_done = 1'b1;
			end else begin
				mode = $urandom_range(0, 3);
				len = $urandom_range(1, 80);
				repeat (len) begin
					@(posedge clk);
					case (mode)
						0: out_stall <= 1'b0;
						1: out_stall <= 1'($urandom_range(0, 1));
						2: out_stall <= ($urandom_range(0, 7) != 0);
						default: out_stall <= ~out_stall;
					endcase
				end
			end
		end
	end

	initial begin
		#2_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	initial begin : stimulus
		logic [FMT_WIDTH-1:0] phase_fmt[8];
		logic [FIELD_WIDTH-1:0] g;
		logic [FIELD_WIDTH-1:0] v;
		logic [FIELD_WIDTH-1:0] m;
		logic [FMT_WIDTH-1:0] fmt;
		int n;
		int phase_count;
		phase_fmt = '{FMT_I8, FMT_U32, FMT_I16, FMT_U64, FMT_U8, FMT_I64, FMT_U16, FMT_I32};
		arst_n = 1'b0;
		in_valid = 1'b0;
		operand_bits = '0;
		operand_format = FMT_U64;
		last_operand = 1'b0;
		cfg_valid = 1'b0;
		result_format = RESULT_FORMAT_RESET;
		burst_left = 0;
		items_sent = 0;
		set_closed = 1'b1;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part under the reset result format.
		send_operand(64'h5a5a_5a5a_5a5a_5a80, FMT_I8, 1'b1);
		send_operand('1, FMT_U64, 1'b1);
		send_operand(64'h8000_0000_0000_0000, FMT_I64, 1'b1);
		send_operand(64'hffff_ffff_ffff_ff00, FMT_U8, 1'b1);
		send_operand(64'd12, FMT_U8, 1'b0);
		send_operand(64'd0, FMT_U32, 1'b0);
		send_operand(64'h1234_0000_0000_ffee, FMT_I16, 1'b0);
		send_operand(64'd30, FMT_U32, 1'b1);
		send_operand(64'hdead_beef_ffff_ffff, FMT_I32, 1'b1);
		send_operand(64'h0000_0000_0000_ffff, FMT_U16, 1'b0);
		send_operand(64'h0000_0000_0000_8000, FMT_I16, 1'b1);
		send_operand('1, FMT_I64, 1'b1);
		send_operand(64'h0000_0000_ffff_ffff, FMT_U32, 1'b0);
		send_operand(64'hffff_ffff_0000_0000, FMT_U64, 1'b1);
		send_operand(64'h8000_0000_0000_0000, FMT_U64, 1'b0);
		send_operand(64'h0000_0000_8000_0000, FMT_I32, 1'b1);
		send_operand(64'd0, FMT_I64, 1'b0);
		send_operand(64'd0, FMT_U16, 1'b1);
		send_operand(64'hffff_ffff_ffff_fffe, FMT_U64, 1'b0);
		send_operand(64'h7fff_ffff_ffff_ffff, FMT_I64, 1'b1);
		send_operand(64'h0000_0000_0000_007f, FMT_I8, 1'b0);
		send_operand(64'h0000_0000_0000_00ff, FMT_I8, 1'b1);

		for (int p = 0; p < 8; p++) begin
			drain_block();
			write_result_format(phase_fmt[p]);
			phase_count = 0;
			while (phase_count < PHASE_ITEMS) begin
				if ($urandom_range(0, 6) == 0) begin
					// noise: any bits, any format, random end of set
					send_operand({$urandom, $urandom}, 3'($urandom_range(0, 7)),
						1'($urandom_range(0, 1)));
					phase_count++;
				end else begin
					case ($urandom_range(0, 3))
						0: g = 64'($urandom_range(1, 1000));
						1: g = 64'd1 << $urandom_range(0, 63);
						2: g = 64'($urandom);
						default: g = {$urandom, $urandom};
					endcase
					n = $urandom_range(1, 6);
					fmt = 3'($urandom_range(0, 7));
					for (int i = 0; i < n; i++) begin
						if ($urandom_range(0, 2) == 0)
							fmt = 3'($urandom_range(0, 7));
						v = g * (($urandom_range(0, 3) == 0) ? {$urandom, $urandom}
							: 64'($urandom_range(0, 5000)));
						if (!fmt[0] && $urandom_range(0, 1))
							v = -v;
						m = (size_t'(fmt[2:1]) == SZ_64) ? '1
							: ((64'd1 << (8 << fmt[2:1])) - 64'd1);
						// scramble the bits the format ignores
						if ($urandom_range(0, 1))
							v = (v & m) | ({$urandom, $urandom} & ~m);
						send_operand(v, fmt, i == n - 1);
						phase_count++;
					end
				end
			end
			if (!set_closed)
				send_operand({$urandom, $urandom}, 3'($urandom_range(0, 7)), 1'b1);
		end

		drain_block();
		if (fail_count == 0 && pending_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

FILE: multi_operand_gcd.f
+incdir+hw/rtl
hw/rtl/mog_pkg.sv
hw/rtl/mog_gcd_core.sv
hw/rtl/multi_operand_gcd.sv
bench/gcd_checker.sv
bench/tb_multi_operand_gcd.sv
